FILE: rtl/spi_pc_pkg.sv
// spi_pc_pkg: shared types, codes and defaults of the spi packet checker
// no dependencies; imported by every module of the block
package spi_pc_pkg;

   // parameter defaults
   localparam int MAX_PAYLOAD_DEFAULT = 64;
   localparam int COUNT_BITS_DEFAULT  = 16;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 4;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   localparam csr_index_type CSR_START_VALUE = csr_index_type'(0);
   localparam csr_index_type CSR_STOP_VALUE  = csr_index_type'(1);

   // verdict codes
   typedef logic [1:0] verdict_type;
   localparam verdict_type VERDICT_GOOD   = 2'd0;
   localparam verdict_type VERDICT_HEADER = 2'd1;
   localparam verdict_type VERDICT_XOR    = 2'd2;
   localparam verdict_type VERDICT_SIZE   = 2'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_first;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  command;
      logic [7:0]  payload_size;
      logic [15:0] good_total;
      logic [15:0] xor_fail_total;
      logic [15:0] header_fail_total;
   } rsp_type;

   // result handed from the frame checker to the output stage
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } result_type;

endpackage

FILE: rtl/spi_pc_core.sv
// spi_pc_core: frame state machine, configuration registers and counters
// depends on spi_pc_pkg
module spi_pc_core #(
   parameter int MAX_PAYLOAD = spi_pc_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int COUNT_BITS  = spi_pc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_take,
   input  spi_pc_pkg::req_type       req_data,
   input  logic                      csr_write,
   input  spi_pc_pkg::csr_index_type csr_index,
   input  logic [7:0]                csr_data,
   output spi_pc_pkg::result_type    result
);
   import spi_pc_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_CMD,
      PH_SIZE,
      PH_DATA,
      PH_CHECK,
      PH_STOP
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [7:0]            start_ff, stop_ff;
   logic [7:0]            cmd_ff, cmd_in;
   logic [7:0]            size_ff, size_in;
   logic [7:0]            left_ff, left_in;
   logic [7:0]            xor_ff, xor_in;
   logic                  xor_ok_ff, xor_ok_in;
   logic [COUNT_BITS-1:0] good_ff, good_in;
   logic [COUNT_BITS-1:0] xfail_ff, xfail_in;
   logic [COUNT_BITS-1:0] hfail_ff, hfail_in;
   logic                  good_bump, xfail_bump, hfail_bump;
   logic [7:0]            left_dec;
   logic [7:0]            rx;

   assign rx       = req_data.rx_byte;
   assign left_dec = left_ff - 8'd1;

   always_comb begin
      phase_in   = phase_ff;
      cmd_in     = cmd_ff;
      size_in    = size_ff;
      left_in    = left_ff;
      xor_in     = xor_ff;
      xor_ok_in  = xor_ok_ff;
      good_bump  = 1'b0;
      xfail_bump = 1'b0;
      hfail_bump = 1'b0;
      result.valid            = 1'b0;
      result.rsp.verdict      = VERDICT_GOOD;
      result.rsp.command      = cmd_ff;
      result.rsp.payload_size = size_ff;
      if (req_take) begin
         if (req_data.buffer_first) begin
            if (rx != start_ff) begin
               hfail_bump              = 1'b1;
               result.valid            = 1'b1;
               result.rsp.verdict      = VERDICT_HEADER;
               result.rsp.command      = 8'd0;
               result.rsp.payload_size = 8'd0;
               phase_in                = PH_IDLE;
            end else begin
               xor_in    = 8'd0;
               xor_ok_in = 1'b0;
               phase_in  = PH_CMD;
            end
         end else begin
            unique case (phase_ff)
               PH_CMD: begin
                  cmd_in   = rx;
                  xor_in   = rx;
                  phase_in = PH_SIZE;
               end
               PH_SIZE: begin
                  size_in = rx;
                  xor_in  = xor_ff ^ rx;
                  if (rx > 8'(MAX_PAYLOAD)) begin
                     hfail_bump              = 1'b1;
                     result.valid            = 1'b1;
                     result.rsp.verdict      = VERDICT_SIZE;
                     result.rsp.payload_size = rx;
                     phase_in                = PH_IDLE;
                  end else begin
                     left_in  = rx;
                     phase_in = (rx == 8'd0) ? PH_CHECK : PH_DATA;
                  end
               end
               PH_DATA: begin
                  xor_in  = xor_ff ^ rx;
                  left_in = left_dec;
                  if (left_dec == 8'd0) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  xor_ok_in = (rx == xor_ff);
                  phase_in  = PH_STOP;
               end
               PH_STOP: begin
                  result.valid = 1'b1;
                  phase_in     = PH_IDLE;
                  if (rx != stop_ff) begin
                     hfail_bump         = 1'b1;
                     result.rsp.verdict = VERDICT_HEADER;
                  end else if (!xor_ok_ff) begin
                     xfail_bump         = 1'b1;
                     result.rsp.verdict = VERDICT_XOR;
                  end else begin
                     good_bump          = 1'b1;
                     result.rsp.verdict = VERDICT_GOOD;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
      // saturating counters
      good_in  = (good_bump && (good_ff != '1)) ? good_ff + 1'b1 : good_ff;
      xfail_in = (xfail_bump && (xfail_ff != '1)) ? xfail_ff + 1'b1 : xfail_ff;
      hfail_in = (hfail_bump && (hfail_ff != '1)) ? hfail_ff + 1'b1 : hfail_ff;
      result.rsp.good_total        = 16'(good_in);
      result.rsp.xor_fail_total    = 16'(xfail_in);
      result.rsp.header_fail_total = 16'(hfail_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         start_ff  <= 8'd0;
         stop_ff   <= 8'd0;
         cmd_ff    <= 8'd0;
         size_ff   <= 8'd0;
         left_ff   <= 8'd0;
         xor_ff    <= 8'd0;
         xor_ok_ff <= 1'b0;
         good_ff   <= '0;
         xfail_ff  <= '0;
         hfail_ff  <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_START_VALUE: start_ff <= csr_data;
               CSR_STOP_VALUE:  stop_ff  <= csr_data;
               default: ;
            endcase
         end
         phase_ff  <= phase_in;
         cmd_ff    <= cmd_in;
         size_ff   <= size_in;
         left_ff   <= left_in;
         xor_ff    <= xor_in;
         xor_ok_ff <= xor_ok_in;
         good_ff   <= good_in;
         xfail_ff  <= xfail_in;
         hfail_ff  <= hfail_in;
      end
   end

endmodule

FILE: rtl/spi_pc_out_stage.sv
// spi_pc_out_stage: result register with one skid entry behind it
// depends on spi_pc_pkg
module spi_pc_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  spi_pc_pkg::result_type result,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output spi_pc_pkg::rsp_type    rsp_payload,
   output logic                   req_stall
);
   import spi_pc_pkg::*;

   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    out_take;

   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         // input is stalled here, so no new result can arrive
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result.valid) begin
         if (!out_valid_ff || out_take) begin
            out_valid_in = 1'b1;
            out_data_in  = result.rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result.rsp;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;
   assign req_stall   = skid_valid_ff;

endmodule

FILE: rtl/spi_packet_checker.sv
// spi_packet_checker: top level of the spi receive frame checker
// depends on spi_pc_pkg, spi_pc_core and spi_pc_out_stage
//
// usage
// - request channel (req_valid / req_stall / req_payload) carries one received
//   byte per request, with buffer_first set on position zero of a buffer
// - response channel (rsp_valid / rsp_stall / rsp_payload) carries one verdict
//   per checked frame plus the command, size and the three saturating totals
// - csr channel (csr_valid / csr_ready / csr_index / csr_data) writes
//   start_value (index 0) and stop_value (index 1); other indexes are dropped;
//   csr_ready is always high, write only while the block is idle
// - throughput: one request per cycle while req_stall is low, set by the
//   frame state machine in spi_pc_core
// - response: registered in the output stage from the request that closes
//   the frame (bad start, oversize length or stop byte)
// - receiver stall: the response register holds its value; a second response
//   goes to a one-entry skid buffer, and only when that is full does
//   req_stall rise, so the byte stream keeps moving while one result waits
// - reset (synchronous): phase idle, registers and totals cleared, no
//   response pending
module spi_packet_checker #(
   parameter int MAX_PAYLOAD = spi_pc_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int COUNT_BITS  = spi_pc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  spi_pc_pkg::req_type       req_payload,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output spi_pc_pkg::rsp_type       rsp_payload,
   // csr write channel
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  spi_pc_pkg::csr_index_type csr_index,
   input  logic [7:0]                csr_data
);
   import spi_pc_pkg::*;

   logic       req_take;
   result_type result;

   // a request is taken when valid and not stalled
   assign req_take  = req_valid && !req_stall;
   // csr writes never wait
   assign csr_ready = 1'b1;

   // frame tracking, totals and registers
   spi_pc_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD),
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .req_take (req_take),
      .req_data (req_payload),
      .csr_write(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .result   (result)
   );

   // response register and skid entry
   spi_pc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .req_stall  (req_stall)
   );

endmodule

FILE: rtl/spi_pc_checker.sv
// spi_pc_checker: port-level assertions for spi_packet_checker, with its bind
// depends on spi_pc_pkg and the spi_packet_checker ports
module spi_pc_checker #(
   parameter int MAX_PAYLOAD = spi_pc_pkg::MAX_PAYLOAD_DEFAULT
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input spi_pc_pkg::rsp_type       rsp_payload
);
   import spi_pc_pkg::*;

   // reset leaves no response pending
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response dropped or changed");

   // request side backs up only behind a pending response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && $past(rsp_stall))
      else $error("request stall without a stalled response");

   // oversize verdict only for sizes above the bound, good and xor verdicts only within it
   a_size_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_payload.verdict == VERDICT_SIZE) == (rsp_payload.payload_size > 8'(MAX_PAYLOAD)))
         || (rsp_payload.verdict == VERDICT_HEADER))
      else $error("size verdict does not match payload size");

endmodule

bind spi_packet_checker spi_pc_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_checker (.*);

FILE: tb/sv/tb_spi_packet_checker.sv
// tb_spi_packet_checker: self-checking bench for the spi receive frame checker
// depends on spi_pc_pkg and spi_packet_checker; a byte-level frame predictor
// judges every accepted request and checks each response in arrival order
`timescale 1ns / 100ps

module tb_spi_packet_checker;
   import spi_pc_pkg::*;

   // bench sizing
   localparam int PAYLOAD_LIMIT  = MAX_PAYLOAD_DEFAULT;
   localparam int TALLY_BITS     = COUNT_BITS_DEFAULT;
   localparam int PHASE_ITEMS    = 360;
   localparam int FLOOD_ITEMS    = 60;
   localparam int SETTLE_CYCLES  = 4;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam int SCRIPT_LEN     = 28;

   // csr indexes past the register list, writes there must be dropped
   localparam csr_index_type CSR_SPARE_LOW = csr_index_type'(2);
   localparam csr_index_type CSR_SPARE_TOP = '1;

   // frame position as seen by the predictor
   typedef enum logic [2:0] {
      WAIT_START, TAKE_CMD, TAKE_SIZE, TAKE_DATA, TAKE_CHECK, TAKE_STOP
   } frame_stage_type;

   // one row of the directed script; fixed rows carry a hand-written verdict
   typedef struct {
      logic [7:0] rx;
      logic       first;
      logic       fixed;
      rsp_type    want;
   } script_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   req_type       req_payload = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rsp_type       rsp_payload;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = '0;
   logic [7:0]    csr_data = '0;

   // travels alongside req_payload so the checker knows which verdict is typed in
   logic    script_fixed = 1'b0;
   rsp_type script_want = '0;

   // predictor state: register copies, frame progress and the three tallies
   logic [7:0]            start_copy = '0;
   logic [7:0]            stop_copy = '0;
   frame_stage_type       stage = WAIT_START;
   logic [7:0]            cmd_copy = '0;
   logic [7:0]            size_copy = '0;
   logic [7:0]            bytes_due = '0;
   logic [7:0]            xor_run = '0;
   logic                  xor_match = 1'b0;
   logic [TALLY_BITS-1:0] good_tally = '0;
   logic [TALLY_BITS-1:0] xor_tally = '0;
   logic [TALLY_BITS-1:0] header_tally = '0;

   rsp_type pending_verdicts[$];
   int      fault_count = 0;
   int      mismatch_count = 0;
   int      fed = 0;
   int      idle_cycles = 0;

   // idling knobs, set per phase by the stimulus process
   int         sender_idle_pct = 0;
   int         stall_pct = 0;
   logic [7:0] cur_start = '0;
   logic [7:0] cur_stop = '0;

   script_row_type script[SCRIPT_LEN];

   spi_packet_checker u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // finish a frame: snapshot the tallies and fall back to waiting for a start
   function automatic rsp_type close_frame(input verdict_type v, input logic [7:0] c,
                                           input logic [7:0] s);
      rsp_type r;
      r.verdict           = v;
      r.command           = c;
      r.payload_size      = s;
      r.good_total        = 16'(good_tally);
      r.xor_fail_total    = 16'(xor_tally);
      r.header_fail_total = 16'(header_tally);
      stage = WAIT_START;
      return r;
   endfunction

   // walks one received byte through the frame; returns 1 when a verdict is due
   function automatic bit judge_byte(input req_type r, output rsp_type res);
      res = '0;
      // a flagged byte always opens a new buffer, dropping any open frame
      if (r.buffer_first) begin
         if (r.rx_byte != start_copy) begin
            if (header_tally != '1) header_tally++;
            res = close_frame(VERDICT_HEADER, 8'h00, 8'h00);
            return 1'b1;
         end
         xor_run   = '0;
         xor_match = 1'b0;
         stage     = TAKE_CMD;
         return 1'b0;
      end
      case (stage)
         TAKE_CMD: begin
            cmd_copy = r.rx_byte;
            xor_run  = r.rx_byte;
            stage    = TAKE_SIZE;
         end
         TAKE_SIZE: begin
            size_copy = r.rx_byte;
            xor_run  ^= r.rx_byte;
            // oversize is reported right away, no payload is read
            if (int'(r.rx_byte) > PAYLOAD_LIMIT) begin
               if (header_tally != '1) header_tally++;
               res = close_frame(VERDICT_SIZE, cmd_copy, size_copy);
               return 1'b1;
            end
            bytes_due = r.rx_byte;
            stage     = (r.rx_byte == 8'd0) ? TAKE_CHECK : TAKE_DATA;
         end
         TAKE_DATA: begin
            xor_run ^= r.rx_byte;
            bytes_due--;
            if (bytes_due == 8'd0) stage = TAKE_CHECK;
         end
         TAKE_CHECK: begin
            xor_match = (r.rx_byte == xor_run);
            stage     = TAKE_STOP;
         end
         TAKE_STOP: begin
            // a bad stop byte wins over a bad check byte
            if (r.rx_byte != stop_copy) begin
               if (header_tally != '1) header_tally++;
               res = close_frame(VERDICT_HEADER, cmd_copy, size_copy);
            end else if (!xor_match) begin
               if (xor_tally != '1) xor_tally++;
               res = close_frame(VERDICT_XOR, cmd_copy, size_copy);
            end else begin
               if (good_tally != '1) good_tally++;
               res = close_frame(VERDICT_GOOD, cmd_copy, size_copy);
            end
            return 1'b1;
         end
         // idle bytes without the first flag are ignored
         default: stage = WAIT_START;
      endcase
      return 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic check_verdict(input rsp_type got);
      rsp_type want;
      if (pending_verdicts.size() == 0) begin
         fault_count++;
         if (mismatch_count < REPORT_LIMIT)
            $display("%0t: response with nothing expected, verdict %0d command %h size %h",
                     $time, got.verdict, got.command, got.payload_size);
         mismatch_count++;
         return;
      end
      want = pending_verdicts.pop_front();
      if (got.verdict !== want.verdict || got.command !== want.command ||
          got.payload_size !== want.payload_size || got.good_total !== want.good_total ||
          got.xor_fail_total !== want.xor_fail_total ||
          got.header_fail_total !== want.header_fail_total) begin
         fault_count++;
         if (mismatch_count < REPORT_LIMIT)
            $display({"%0t: mismatch (expected/actual) verdict %0d/%0d command %h/%h ",
                      "size %h/%h good %0d/%0d xor %0d/%0d header %0d/%0d"}, $time,
                     want.verdict, got.verdict, want.command, got.command,
                     want.payload_size, got.payload_size, want.good_total, got.good_total,
                     want.xor_fail_total, got.xor_fail_total,
                     want.header_fail_total, got.header_fail_total);
         mismatch_count++;
      end
   endtask

   // all handshakes are sampled here, at the edge, on pre-edge values;
   // requests are handled before responses so a same-edge verdict is queued first
   always @(posedge clock) begin
      rsp_type predicted;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_VALUE: start_copy = csr_data;
               CSR_STOP_VALUE:  stop_copy = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (judge_byte(req_payload, predicted) && !script_fixed)
               pending_verdicts.push_back(predicted);
            if (script_fixed)
               pending_verdicts.push_back(script_want);
         end
         if (rsp_valid && !rsp_stall)
            check_verdict(rsp_payload);
      end
   end

   // watchdog: any cycle without a handshake counts toward the limit
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // ---------------------------------------------------------------------
   // idling
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   function automatic script_row_type plain(input logic [7:0] rx, input logic first);
      script_row_type row;
      row.rx    = rx;
      row.first = first;
      row.fixed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic script_row_type sure(input logic [7:0] rx, input logic first,
                                           input verdict_type v, input logic [7:0] c,
                                           input logic [7:0] s, input int g, input int x,
                                           input int h);
      script_row_type row;
      row = plain(rx, first);
      row.fixed                  = 1'b1;
      row.want.verdict           = v;
      row.want.command           = c;
      row.want.payload_size      = s;
      row.want.good_total        = 16'(g);
      row.want.xor_fail_total    = 16'(x);
      row.want.header_fail_total = 16'(h);
      return row;
   endfunction

   // one request, entered and left at a rising edge; returns on acceptance
   task automatic send(input logic [7:0] rx, input logic first, input logic fixed,
                       input rsp_type want);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid                <= 1'b1;
      req_payload.rx_byte      <= rx;
      req_payload.buffer_first <= first;
      script_fixed             <= fixed;
      script_want              <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // a request the block acts on
   task automatic push_byte(input logic [7:0] rx, input logic first);
      send(rx, first, 1'b0, '0);
      fed++;
   endtask

   // sender goes quiet until every expected verdict has been taken
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller lowers it after the last write
   task automatic write_reg(input csr_index_type idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // one random buffer: mostly well-formed frames with random content,
   // the rest cut-off frames, bad start bytes and stray idle bytes
   task automatic feed_frame();
      int         kind;
      int         pick;
      int         size;
      logic [7:0] cmd;
      logic [7:0] sum;
      logic [7:0] data;
      logic [7:0] body[$];
      kind = $urandom_range(0, 99);
      if (kind >= 90) begin
         // stray bytes while idle are ignored and do not count
         repeat ($urandom_range(1, 4)) send(8'($urandom), 1'b0, 1'b0, '0);
         return;
      end
      if (kind >= 80) begin
         push_byte(cur_start ^ 8'($urandom_range(1, 255)), 1'b1);
         return;
      end
      cmd  = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 80)
         size = $urandom_range(0, 8);
      else if (pick < 95)
         size = $urandom_range(9, PAYLOAD_LIMIT);
      else
         size = $urandom_range(PAYLOAD_LIMIT + 1, 255);
      body.push_back(cmd);
      body.push_back(8'(size));
      sum = cmd ^ 8'(size);
      // an oversize frame ends at its size byte
      if (size <= PAYLOAD_LIMIT) begin
         repeat (size) begin
            data = 8'($urandom);
            body.push_back(data);
            sum ^= data;
         end
         body.push_back(($urandom_range(0, 99) < 85) ? sum : sum ^ 8'($urandom_range(1, 255)));
         body.push_back(($urandom_range(0, 99) < 85) ? cur_stop :
                        cur_stop ^ 8'($urandom_range(1, 255)));
      end
      // cut-off frame: the next flagged byte drops it
      if (kind >= 70) begin
         pick = $urandom_range(0, body.size() - 1);
         while (body.size() > pick) void'(body.pop_back());
      end
      push_byte(cur_start, 1'b1);
      foreach (body[i]) push_byte(body[i], 1'b0);
   endtask

   initial begin
      int         goal;
      bit         paused;
      logic [7:0] next_start;
      logic [7:0] next_stop;

      // directed script, run with the reset register values (both zero)
      script = '{
         plain(8'h55, 1'b0),                                        // idle byte, ignored
         sure(8'h01, 1'b1, VERDICT_HEADER, 8'h00, 8'h00, 0, 0, 1),  // wrong start
         plain(8'h00, 1'b1),
         plain(8'hFF, 1'b0),                                        // command all ones
         plain(8'h00, 1'b0),                                        // empty payload
         plain(8'hFF, 1'b0),
         sure(8'h00, 1'b0, VERDICT_GOOD, 8'hFF, 8'h00, 1, 0, 1),
         plain(8'h00, 1'b1),
         plain(8'h00, 1'b0),
         sure(8'h41, 1'b0, VERDICT_SIZE, 8'h00, 8'h41, 1, 0, 2),    // one past the bound
         plain(8'h00, 1'b1),
         plain(8'h12, 1'b0),
         plain(8'h01, 1'b0),
         plain(8'hFF, 1'b0),
         plain(8'h00, 1'b0),                                        // check byte wrong
         sure(8'h00, 1'b0, VERDICT_XOR, 8'h12, 8'h01, 1, 1, 2),
         plain(8'h00, 1'b1),
         plain(8'h34, 1'b0),
         plain(8'h00, 1'b0),
         plain(8'h00, 1'b0),                                        // check byte wrong
         sure(8'hFF, 1'b0, VERDICT_HEADER, 8'h34, 8'h00, 1, 1, 3),  // stop wins
         plain(8'h00, 1'b1),
         plain(8'h01, 1'b0),
         plain(8'h00, 1'b1),                                        // restart drops frame
         plain(8'h02, 1'b0),
         plain(8'h00, 1'b0),
         plain(8'h02, 1'b0),
         plain(8'h00, 1'b0)
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         send(script[i].rx, script[i].first, script[i].fixed, script[i].want);
         fed++;
      end

      // random phases, each with its own register setting and idling mix
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         case (ph)
            0: begin
               next_start = 8'hFF; next_stop = 8'hFF;
               sender_idle_pct = 0; stall_pct = 0;
            end
            1: begin
               next_start = 8'hA5; next_stop = 8'h5A;
               sender_idle_pct = 81; stall_pct = 0;
            end
            2: begin
               next_start = 8'($urandom); next_stop = 8'($urandom);
               sender_idle_pct = 0; stall_pct = 81;
            end
            3: begin
               next_start = 8'h00; next_stop = 8'hFF;
               sender_idle_pct = 26; stall_pct = 26;
            end
            default: begin
               next_start = 8'($urandom); next_stop = 8'h00;
               sender_idle_pct = 0; stall_pct = 0;
            end
         endcase
         write_reg(CSR_START_VALUE, next_start);
         write_reg(CSR_STOP_VALUE, next_stop);
         // writes past the register list must leave both values alone
         if (ph == 1) begin
            write_reg(CSR_SPARE_LOW, 8'($urandom));
            write_reg(CSR_SPARE_TOP, 8'($urandom));
         end
         csr_valid  <= 1'b0;
         cur_start  = next_start;
         cur_stop   = next_stop;
         goal       = fed + PHASE_ITEMS;
         paused     = 1'b0;
         while (fed < goal) begin
            feed_frame();
            // mid-phase pause with the receiver stalling hard
            if (ph == 2 && !paused && fed > goal - PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
         end
         // a bad start byte closes whatever frame is still open
         push_byte(cur_start ^ 8'h80, 1'b1);
      end

      // burst of bad start bytes back to back, then a few frames show the
      // other tallies still moving
      sender_idle_pct = 0;
      stall_pct       = 0;
      repeat (FLOOD_ITEMS) push_byte(cur_start ^ 8'($urandom_range(1, 255)), 1'b1);
      repeat (6) feed_frame();
      push_byte(cur_start ^ 8'h80, 1'b1);

      drain();
      fault_count += pending_verdicts.size();
      if (fault_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
